@@ hw/rtl/shig_pkg.sv @@
// ----------------------------------------------------------------------------
// shig_pkg
// Shared types and constants of the hashed scatter instance generator.
// ----------------------------------------------------------------------------
`default_nettype none

package shig_pkg;

	localparam logic [63:0] MIX_A = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_B = 64'h94d049bb133111eb;

	localparam logic [6:0] MAX_INSTANCES = 7'd64;
	localparam logic [6:0] ROW_STRIDE    = 7'd7;
	localparam int JOB_DEPTH = 2;
	localparam int RES_DEPTH = 2;

	localparam logic [1:0] REG_WORLD_SEED     = 2'd0;
	localparam logic [1:0] REG_INSTANCE_COUNT = 2'd1;
	localparam logic [1:0] REG_CELL_SIZE      = 2'd2;

	localparam logic [63:0] SEED_RESET  = 64'd0;
	localparam logic [6:0]  COUNT_RESET = 7'd16;
	localparam logic [30:0] SIZE_RESET  = 31'd4194304;

	typedef struct packed {
		logic [63:0] key_mix;
		logic [31:0] ox;
		logic [31:0] oy;
		logic [31:0] oz;
		logic [6:0]  count;
		logic [30:0] step;
	} job_t;

	typedef struct packed {
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
		logic [15:0] scale_code;
		logic [15:0] rotation_code;
		logic [63:0] instance_seed;
		logic        last_of_cell;
	} res_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_LOAD,
		B_MULA,
		B_MULB,
		B_PLACE,
		B_PUSH
	} back_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/shig_fifo.sv @@
// ----------------------------------------------------------------------------
// shig_fifo
// Small register queue used between the stages and at the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module shig_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/shig_front.sv @@
// ----------------------------------------------------------------------------
// shig_front
// Accepts cell requests, saturates the count, divides out the grid step.
// ----------------------------------------------------------------------------
`default_nettype none

module shig_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [63:0] cell_key,
	input  wire logic [31:0] origin_x,
	input  wire logic [31:0] origin_y,
	input  wire logic [31:0] origin_z,
	input  wire logic [63:0] world_seed,
	input  wire logic [6:0]  instance_count,
	input  wire logic [30:0] cell_size,
	output logic             job_push,
	output shig_pkg::job_t   job,
	input  wire logic        job_full
);

	shig_pkg::front_state_t state_q, state_d;

	shig_pkg::job_t job_q;
	logic [30:0]    quot_q;
	logic [6:0]     rem_q;
	logic [4:0]     iter_q;
	logic [6:0]     count_sat;
	logic [6:0]     sh;
	logic           ge;
	logic           accept;

	assign count_sat = (instance_count > shig_pkg::MAX_INSTANCES) ?
		shig_pkg::MAX_INSTANCES : instance_count;
	assign accept = push & ~full;
	assign sh     = {rem_q[5:0], quot_q[30]};
	assign ge     = (sh >= job_q.count);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			shig_pkg::F_IDLE: if (push && count_sat != '0) state_d = shig_pkg::F_DIV;
			shig_pkg::F_DIV:  if (iter_q == 5'd30) state_d = shig_pkg::F_PUSH;
			shig_pkg::F_PUSH: if (!job_full) state_d = shig_pkg::F_IDLE;
			default:          state_d = shig_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		full      = (state_q != shig_pkg::F_IDLE);
		job_push  = (state_q == shig_pkg::F_PUSH);
		job       = job_q;
		job.step  = quot_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= shig_pkg::F_IDLE;
			iter_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == shig_pkg::F_IDLE) begin
				iter_q <= '0;
			end else if (state_q == shig_pkg::F_DIV) begin
				iter_q <= iter_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_q.key_mix <= world_seed ^ cell_key;
			job_q.ox      <= origin_x;
			job_q.oy      <= origin_y;
			job_q.oz      <= origin_z;
			job_q.count   <= count_sat;
			job_q.step    <= '0;
			quot_q        <= cell_size;
			rem_q         <= '0;
		end else if (state_q == shig_pkg::F_DIV) begin
			rem_q  <= ge ? sh - job_q.count : sh;
			quot_q <= {quot_q[29:0], ge};
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/shig_back.sv @@
// ----------------------------------------------------------------------------
// shig_back
// Runs the splitmix64 chain on one shared 32x32 multiplier and places
// each instance on the jittered grid.
// ----------------------------------------------------------------------------
`default_nettype none

module shig_back (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  shig_pkg::job_t job,
	input  wire logic      job_empty,
	output logic           job_pop,
	output shig_pkg::res_t res,
	output logic           res_push,
	input  wire logic      res_full
);

	shig_pkg::back_state_t state_q, state_d;

	shig_pkg::job_t job_q;
	logic [63:0]    v_q;
	logic [63:0]    st_q;
	logic [63:0]    acc_q;
	logic [63:0]    prod_q;
	logic [31:0]    px_q;
	logic [1:0]     phase_q;
	logic [6:0]     i_q;
	logic [6:0]     row_q;
	logic           first_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] load_src;
	logic [63:0] acc_fin;
	logic [63:0] cst;
	logic [37:0] cx_full;
	logic [37:0] rz_full;
	logic [31:0] pz;
	logic [7:0]  row_n;
	logic        last;

	assign cst      = (state_q == shig_pkg::B_MULA) ? shig_pkg::MIX_A : shig_pkg::MIX_B;
	assign load_src = first_q ? job_q.key_mix : st_q + 64'(i_q) + 64'd1;
	assign acc_fin  = acc_q + {prod_q[31:0], 32'd0};
	assign cx_full  = job_q.step * i_q;
	assign rz_full  = job_q.step * row_q;
	assign pz       = job_q.oz + rz_full[31:0] + prod_q[47:16];
	assign last     = (i_q + 7'd1 == job_q.count);

	always_comb begin
		row_n = {1'b0, row_q} + {1'b0, shig_pkg::ROW_STRIDE};
		for (int k = 0; k < 7; k++) begin
			if (row_n >= {1'b0, job_q.count}) begin
				row_n = row_n - {1'b0, job_q.count};
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			shig_pkg::B_IDLE:  if (!job_empty) state_d = shig_pkg::B_LOAD;
			shig_pkg::B_LOAD:  state_d = shig_pkg::B_MULA;
			shig_pkg::B_MULA:  if (phase_q == 2'd3) state_d = shig_pkg::B_MULB;
			shig_pkg::B_MULB:  if (phase_q == 2'd3) begin
				state_d = first_q ? shig_pkg::B_LOAD : shig_pkg::B_PLACE;
			end
			shig_pkg::B_PLACE: if (phase_q == 2'd1) state_d = shig_pkg::B_PUSH;
			shig_pkg::B_PUSH:  if (!res_full) begin
				state_d = last ? shig_pkg::B_IDLE : shig_pkg::B_LOAD;
			end
			default:           state_d = shig_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		job_pop  = (state_q == shig_pkg::B_IDLE) & ~job_empty;
		res_push = (state_q == shig_pkg::B_PUSH);
		mul_a    = v_q[31:0];
		mul_b    = cst[31:0];
		if (state_q == shig_pkg::B_PLACE) begin
			mul_a = (phase_q == 2'd0) ? {16'd0, st_q[23:8]} : {16'd0, st_q[39:24]};
			mul_b = {1'b0, job_q.step};
		end else begin
			unique case (phase_q)
				2'd1:    mul_a = v_q[63:32];
				2'd2:    mul_b = cst[63:32];
				default: mul_a = v_q[31:0];
			endcase
		end
		res.pos_x         = px_q;
		res.pos_y         = job_q.oy;
		res.pos_z         = pz;
		res.scale_code    = st_q[55:40];
		res.rotation_code = st_q[63:48];
		res.instance_seed = st_q;
		res.last_of_cell  = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= shig_pkg::B_IDLE;
			phase_q <= '0;
			first_q <= 1'b0;
			i_q     <= '0;
			row_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				phase_q <= '0;
			end else begin
				phase_q <= phase_q + 1'b1;
			end
			if (job_pop) begin
				first_q <= 1'b1;
				i_q     <= '0;
				row_q   <= '0;
			end else if (state_q == shig_pkg::B_MULB && phase_q == 2'd3) begin
				first_q <= 1'b0;
			end else if (state_q == shig_pkg::B_PUSH && !res_full && !last) begin
				i_q   <= i_q + 1'b1;
				row_q <= row_n[6:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job;
		end
		// hold the z jitter product while the result waits
		if (state_q != shig_pkg::B_PUSH) begin
			prod_q <= mul_a * mul_b;
		end
		unique case (state_q)
			shig_pkg::B_LOAD: v_q <= load_src ^ (load_src >> 30);
			shig_pkg::B_MULA, shig_pkg::B_MULB: begin
				if (phase_q == 2'd1) begin
					acc_q <= prod_q;
				end else if (phase_q == 2'd2) begin
					acc_q <= acc_fin;
				end else if (phase_q == 2'd3) begin
					if (state_q == shig_pkg::B_MULA) begin
						v_q <= acc_fin ^ (acc_fin >> 27);
					end else begin
						st_q <= acc_fin ^ (acc_fin >> 31);
					end
				end
			end
			shig_pkg::B_PLACE: begin
				if (phase_q == 2'd1) begin
					px_q <= job_q.ox + cx_full[31:0] + prod_q[47:16];
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

@@ hw/rtl/hashed_scatter_instance_generator_unit.sv @@
// ----------------------------------------------------------------------------
// hashed_scatter_instance_generator_unit
// Jittered grid scatter of instances in a cell from a splitmix64 chain.
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  request   push / full      cell_key, origin_x, origin_y, origin_z
//  result    pop / empty      pos_x..last_of_cell, one per instance
//  config    cfg_we           cfg_index, cfg_data
//
// Front: one cell at a time through the 31-step serial step divider;
// a zero-count cell is taken and dropped.
// Back: takes the job and mixes the cell seed, then per instance steps
// through LOAD, MULA, MULB, PLACE and PUSH on the one shared 32x32
// multiplier (two 64-bit products of three partials each). The next
// cell's division overlaps the back's work on a cell. Reset clears control
// state and the configuration registers; datapath registers are loaded before use.
// A full result queue stalls the back only; the front waits on the job queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_scatter_instance_generator_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [63:0] cell_key,
	input  wire logic [31:0] origin_x,
	input  wire logic [31:0] origin_y,
	input  wire logic [31:0] origin_z,
	input  wire logic        pop,
	output logic             empty,
	output logic [31:0]      pos_x,
	output logic [31:0]      pos_y,
	output logic [31:0]      pos_z,
	output logic [15:0]      scale_code,
	output logic [15:0]      rotation_code,
	output logic [63:0]      instance_seed,
	output logic             last_of_cell,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	logic [63:0] world_seed_q;
	logic [6:0]  instance_count_q;
	logic [30:0] cell_size_q;

	shig_pkg::job_t job_in, job_out;
	shig_pkg::res_t res_in, res_out;
	logic job_push, job_full, job_pop, job_empty;
	logic res_push, res_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			world_seed_q     <= shig_pkg::SEED_RESET;
			instance_count_q <= shig_pkg::COUNT_RESET;
			cell_size_q      <= shig_pkg::SIZE_RESET;
		end else if (cfg_we) begin
			priority case (cfg_index)
				shig_pkg::REG_WORLD_SEED:     world_seed_q     <= cfg_data;
				shig_pkg::REG_INSTANCE_COUNT: instance_count_q <= cfg_data[6:0];
				shig_pkg::REG_CELL_SIZE:      cell_size_q      <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	shig_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.cell_key       (cell_key),
		.origin_x       (origin_x),
		.origin_y       (origin_y),
		.origin_z       (origin_z),
		.world_seed     (world_seed_q),
		.instance_count (instance_count_q),
		.cell_size      (cell_size_q),
		.job_push       (job_push),
		.job            (job_in),
		.job_full       (job_full)
	);

	shig_fifo #(
		.WIDTH ($bits(shig_pkg::job_t)),
		.DEPTH (shig_pkg::JOB_DEPTH)
	) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  (job_in),
		.full   (job_full),
		.pop    (job_pop),
		.rdata  (job_out),
		.empty  (job_empty)
	);

	shig_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job_out),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.res       (res_in),
		.res_push  (res_push),
		.res_full  (res_full)
	);

	shig_fifo #(
		.WIDTH ($bits(shig_pkg::res_t)),
		.DEPTH (shig_pkg::RES_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	assign pos_x         = res_out.pos_x;
	assign pos_y         = res_out.pos_y;
	assign pos_z         = res_out.pos_z;
	assign scale_code    = res_out.scale_code;
	assign rotation_code = res_out.rotation_code;
	assign instance_seed = res_out.instance_seed;
	assign last_of_cell  = res_out.last_of_cell;

endmodule

`default_nettype wire
